// ===== hw/rtl/s2e_pkg.sv =====
package s2e_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_ZERO_LIMIT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DBL_TOL    = 2'd1;
  localparam logic [31:0] ZERO_LIMIT_RST = 32'd1;
  localparam logic [31:0] DBL_TOL_RST    = 32'd42950;

  // result kind
  typedef enum logic [1:0] {
    CASE_ZERO     = 2'd0,
    CASE_DOUBLE   = 2'd1,
    CASE_DISTINCT = 2'd2
  } case_e;

  // square root: 68-bit radicand, 34-bit root, one root bit per stage
  localparam int unsigned SqInW   = 68;
  localparam int unsigned SqRootW = 34;
  localparam int unsigned SqRemW  = 37;
  localparam int unsigned SqSteps = SqRootW;

  // vector division: 30 quotient bits, one per stage
  localparam int unsigned DivSteps = 30;
  localparam int unsigned DivRemW  = 35;
  localparam int unsigned NumW     = 37;
  localparam logic [31:0] VEC_ONE  = 32'h4000_0000;

  typedef struct packed {
    logic [SqRemW-1:0]  rem;
    logic [SqRootW-1:0] root;
    logic [SqInW-1:0]   n;
  } sqrt_t;

  typedef struct packed {
    logic [DivRemW-1:0]  rem;
    logic [DivSteps-1:0] quo;
  } div_t;

  // carried alongside the first square root
  typedef struct packed {
    logic signed [31:0] a11;
    logic signed [31:0] a21;
    logic signed [31:0] a22;
    logic signed [32:0] sum;
    logic [31:0]        half;
    logic [63:0]        sq21;
    case_e              code;
  } c1_t;

  // carried alongside the second square root
  typedef struct packed {
    logic [31:0]          eig_s;
    logic [31:0]          eig_l;
    logic signed [NumW-1:0] numx;
    logic signed [NumW-1:0] numy;
    logic                 vdef;
    case_e                code;
  } c2_t;

  // carried alongside the divider
  typedef struct packed {
    logic [31:0]        eig_s;
    logic [31:0]        eig_l;
    logic [SqRootW-1:0] q;
    logic               negx;
    logic               negy;
    logic               clampx;
    logic               clampy;
    logic               vdef;
    case_e              code;
  } c3_t;

  // one restoring square root step
  function automatic sqrt_t sqrt_step(sqrt_t s);
    sqrt_t o;
    logic [SqRemW-1:0] cur;
    logic [SqRemW-1:0] trial;
    cur   = {s.rem[SqRemW-3:0], s.n[SqInW-1 -: 2]};
    trial = {1'b0, s.root, 2'b01};
    o.n   = {s.n[SqInW-3:0], 2'b00};
    if (cur >= trial) begin
      o.rem  = cur - trial;
      o.root = {s.root[SqRootW-2:0], 1'b1};
    end else begin
      o.rem  = cur;
      o.root = {s.root[SqRootW-2:0], 1'b0};
    end
    return o;
  endfunction

  // one restoring division step
  function automatic div_t div_step(div_t d, logic [SqRootW-1:0] q);
    div_t o;
    logic [DivRemW-1:0] cur;
    cur = {d.rem[DivRemW-2:0], 1'b0};
    if (cur >= {1'b0, q}) begin
      o.rem = cur - {1'b0, q};
      o.quo = {d.quo[DivSteps-2:0], 1'b1};
    end else begin
      o.rem = cur;
      o.quo = {d.quo[DivSteps-2:0], 1'b0};
    end
    return o;
  endfunction

  // saturate to 32-bit signed
  function automatic logic [31:0] sat32(logic signed [35:0] x);
    logic [31:0] r;
    if (x > 36'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (x < -36'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/symmetric_2x2_eigen_decompose.sv =====
// channel  | dir | signals                               | word
// s_axis   | in  | tvalid tready tdata[95:0]             | one matrix
// m_axis   | out | tvalid tready tdata[127:0] tuser[1:0] | eigen pair and vector
// cfg      | in  | valid ready index[1:0] data[31:0]     | one register write
//
// one matrix enters per cycle while the output word is not held
// the 108 register stages include two 34-stage square roots and a 30-stage divider
// the whole pipe moves together; it halts only while the output word is held
// rst_ni clears all valid bits and sets the configuration registers to their reset values
module symmetric_2x2_eigen_decompose
  import s2e_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // entry_11, entry_21, entry_22
  input  logic [95:0]        s_axis_tdata_i,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // eigen_small, eigen_large, vec_x, vec_y
  output logic [127:0]       m_axis_tdata_o,
  // case_code
  output logic [1:0]         m_axis_tuser_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  logic        en;
  logic [31:0] zlim_q, tol_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zlim_q <= ZERO_LIMIT_RST;
      tol_q  <= DBL_TOL_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_ZERO_LIMIT) zlim_q <= cfg_data_i;
      if (cfg_index_i == CFG_DBL_TOL)    tol_q  <= cfg_data_i;
    end
  end

  // ---------------- stage 1: magnitudes and squares
  logic signed [31:0] in11, in21, in22;
  logic signed [32:0] in_sum, in_diff;
  logic [32:0]        in_dd;
  logic [31:0]        in_m11, in_m21, in_m22;
  logic               s1_v_q;
  logic signed [31:0] s1_a11_q, s1_a21_q, s1_a22_q;
  logic signed [32:0] s1_sum_q;
  logic [31:0]        s1_half_q;
  logic [63:0]        s1_sq11_q, s1_sq22_q, s1_sq21_q;
  logic [65:0]        s1_dd2_q;

  assign in11    = s_axis_tdata_i[31:0];
  assign in21    = s_axis_tdata_i[63:32];
  assign in22    = s_axis_tdata_i[95:64];
  assign in_sum  = 33'(in11) + 33'(in22);
  assign in_diff = 33'(in11) - 33'(in22);
  assign in_dd   = in_diff[32] ? 33'(-in_diff) : 33'(in_diff);
  assign in_m11  = in11[31] ? 32'(-in11) : 32'(in11);
  assign in_m21  = in21[31] ? 32'(-in21) : 32'(in21);
  assign in_m22  = in22[31] ? 32'(-in22) : 32'(in22);

  assign en = ~m_axis_tvalid_o | m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else if (en) s1_v_q <= s_axis_tvalid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_a11_q  <= in11;
      s1_a21_q  <= in21;
      s1_a22_q  <= in22;
      s1_sum_q  <= in_sum;
      s1_half_q <= in_sum[32:1];
      s1_sq11_q <= in_m11 * in_m11;
      s1_sq22_q <= in_m22 * in_m22;
      s1_sq21_q <= in_m21 * in_m21;
      s1_dd2_q  <= in_dd * in_dd;
    end
  end

  // ---------------- stage 2: squared norm and discriminant
  logic        s2_v_q;
  c1_t         s2_c_q;
  logic [63:0] s2_norm_q;
  logic [65:0] s2_delta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else if (en) s2_v_q <= s1_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_c_q.a11  <= s1_a11_q;
      s2_c_q.a21  <= s1_a21_q;
      s2_c_q.a22  <= s1_a22_q;
      s2_c_q.sum  <= s1_sum_q;
      s2_c_q.half <= s1_half_q;
      s2_c_q.sq21 <= s1_sq21_q;
      s2_c_q.code <= CASE_DISTINCT;
      s2_norm_q   <= s1_sq11_q + s1_sq22_q + s1_sq21_q;
      s2_delta_q  <= s1_dd2_q + {s1_sq21_q, 2'b00};
    end
  end

  // ---------------- stage 3: zero test and tolerance partial products
  logic        s3_v_q, s3_zero_q;
  c1_t         s3_c_q;
  logic [63:0] s3_plo_q, s3_phi_q;
  logic [65:0] s3_delta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_v_q <= 1'b0;
    else if (en) s3_v_q <= s2_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_c_q     <= s2_c_q;
      s3_zero_q  <= s2_norm_q < {32'd0, zlim_q};
      s3_plo_q   <= tol_q * s2_norm_q[31:0];
      s3_phi_q   <= tol_q * s2_norm_q[63:32];
      s3_delta_q <= s2_delta_q;
    end
  end

  // ---------------- stage 4: double root test, case decision
  logic        s4_v_q;
  c1_t         s4_c_q;
  sqrt_t       s4_sq_q;
  logic [95:0] s3_rhs;
  logic        s3_dbl;
  c1_t         s3_c_dec;

  assign s3_rhs = {32'd0, s3_plo_q} + {s3_phi_q, 32'd0};
  assign s3_dbl = {s3_delta_q, 32'd0} < {2'b00, s3_rhs};

  // zero matrix wins over double root
  always_comb begin
    s3_c_dec = s3_c_q;
    if (s3_zero_q)   s3_c_dec.code = CASE_ZERO;
    else if (s3_dbl) s3_c_dec.code = CASE_DOUBLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_v_q <= 1'b0;
    else if (en) s4_v_q <= s3_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_c_q       <= s3_c_dec;
      s4_sq_q.rem  <= '0;
      s4_sq_q.root <= '0;
      s4_sq_q.n    <= {2'b00, s3_delta_q};
    end
  end

  // ---------------- first square root, one root bit per stage
  logic  r1_v_q [SqSteps];
  sqrt_t r1_q   [SqSteps];
  c1_t   r1_c_q [SqSteps];

  for (genvar i = 0; i < SqSteps; i++) begin : g_root1
    if (i == 0) begin : g_head
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) r1_v_q[i] <= 1'b0;
        else if (en) r1_v_q[i] <= s4_v_q;
      end
      always_ff @(posedge clk_i) begin
        if (en) begin
          r1_q[i]   <= sqrt_step(s4_sq_q);
          r1_c_q[i] <= s4_c_q;
        end
      end
    end else begin : g_body
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) r1_v_q[i] <= 1'b0;
        else if (en) r1_v_q[i] <= r1_v_q[i-1];
      end
      always_ff @(posedge clk_i) begin
        if (en) begin
          r1_q[i]   <= sqrt_step(r1_q[i-1]);
          r1_c_q[i] <= r1_c_q[i-1];
        end
      end
    end
  end

  // ---------------- e1: eigenvalues and shifted diagonal
  c1_t                r1_last;
  logic signed [35:0] e_sum, e_root, e_lo, e_hi, e_l1, e_l2;
  logic               e1_v_q;
  c1_t                e1_c_q;
  logic signed [35:0] e1_l1_q, e1_l2_q, e1_d1_q, e1_d2_q;

  assign r1_last = r1_c_q[SqSteps-1];
  assign e_sum   = 36'(r1_last.sum);
  assign e_root  = {2'b00, r1_q[SqSteps-1].root};
  assign e_lo    = e_sum - e_root;
  assign e_hi    = e_sum + e_root;
  assign e_l1    = e_lo >>> 1;
  assign e_l2    = e_hi >>> 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) e1_v_q <= 1'b0;
    else if (en) e1_v_q <= r1_v_q[SqSteps-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_c_q  <= r1_last;
      e1_l1_q <= e_l1;
      e1_l2_q <= e_l2;
      e1_d1_q <= 36'(r1_last.a11) - e_l1;
      e1_d2_q <= 36'(r1_last.a22) - e_l1;
    end
  end

  // ---------------- e2: column squares, final eigenvalues
  logic [35:0]        e1_md1, e1_md2;
  logic               e2_v_q, e2_vdef_q;
  case_e              e2_code_q;
  logic [31:0]        e2_eig_s_q, e2_eig_l_q;
  logic [67:0]        e2_sqd1_q, e2_sqd2_q;
  logic [63:0]        e2_sq21_q;
  logic signed [35:0] e2_d1_q, e2_d2_q;
  logic signed [31:0] e2_a21_q;

  assign e1_md1 = e1_d1_q[35] ? 36'(-e1_d1_q) : 36'(e1_d1_q);
  assign e1_md2 = e1_d2_q[35] ? 36'(-e1_d2_q) : 36'(e1_d2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) e2_v_q <= 1'b0;
    else if (en) e2_v_q <= e1_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e2_sqd1_q <= e1_md1[33:0] * e1_md1[33:0];
      e2_sqd2_q <= e1_md2[33:0] * e1_md2[33:0];
      e2_sq21_q <= e1_c_q.sq21;
      e2_d1_q   <= e1_d1_q;
      e2_d2_q   <= e1_d2_q;
      e2_a21_q  <= e1_c_q.a21;
      e2_code_q <= e1_c_q.code;
      e2_vdef_q <= e1_c_q.code != CASE_DISTINCT;
      case (e1_c_q.code)
        CASE_ZERO: begin
          e2_eig_s_q <= '0;
          e2_eig_l_q <= '0;
        end
        CASE_DOUBLE: begin
          e2_eig_s_q <= e1_c_q.half;
          e2_eig_l_q <= e1_c_q.half;
        end
        default: begin
          e2_eig_s_q <= sat32(e1_l1_q);
          e2_eig_l_q <= sat32(e1_l2_q);
        end
      endcase
    end
  end

  // ---------------- e3: column norms
  logic               e3_v_q;
  logic [67:0]        e3_n1_q, e3_n2_q;
  c2_t                e3_c_q;
  logic signed [35:0] e3_d1_q, e3_d2_q;
  logic signed [31:0] e3_a21_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) e3_v_q <= 1'b0;
    else if (en) e3_v_q <= e2_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e3_n1_q       <= e2_sqd1_q + {4'd0, e2_sq21_q};
      e3_n2_q       <= e2_sqd2_q + {4'd0, e2_sq21_q};
      e3_d1_q       <= e2_d1_q;
      e3_d2_q       <= e2_d2_q;
      e3_a21_q      <= e2_a21_q;
      e3_c_q.eig_s  <= e2_eig_s_q;
      e3_c_q.eig_l  <= e2_eig_l_q;
      e3_c_q.numx   <= '0;
      e3_c_q.numy   <= '0;
      e3_c_q.vdef   <= e2_vdef_q;
      e3_c_q.code   <= e2_code_q;
    end
  end

  // ---------------- e4: pick the larger column
  logic        e3_sel;
  logic        e4_v_q;
  c2_t         e4_c_q;
  sqrt_t       e4_sq_q;
  c2_t         e3_c_pick;
  logic [67:0] e3_n_pick;

  assign e3_sel = e3_n2_q < e3_n1_q;

  always_comb begin
    e3_c_pick = e3_c_q;
    if (e3_sel) begin
      e3_n_pick      = e3_n1_q;
      e3_c_pick.numx = -NumW'(e3_a21_q);
      e3_c_pick.numy = NumW'(e3_d1_q);
    end else begin
      e3_n_pick      = e3_n2_q;
      e3_c_pick.numx = -NumW'(e3_d2_q);
      e3_c_pick.numy = NumW'(e3_a21_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) e4_v_q <= 1'b0;
    else if (en) e4_v_q <= e3_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e4_c_q       <= e3_c_pick;
      e4_sq_q.rem  <= '0;
      e4_sq_q.root <= '0;
      e4_sq_q.n    <= e3_n_pick;
    end
  end

  // ---------------- second square root
  logic  r2_v_q [SqSteps];
  sqrt_t r2_q   [SqSteps];
  c2_t   r2_c_q [SqSteps];

  for (genvar i = 0; i < SqSteps; i++) begin : g_root2
    if (i == 0) begin : g_head
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) r2_v_q[i] <= 1'b0;
        else if (en) r2_v_q[i] <= e4_v_q;
      end
      always_ff @(posedge clk_i) begin
        if (en) begin
          r2_q[i]   <= sqrt_step(e4_sq_q);
          r2_c_q[i] <= e4_c_q;
        end
      end
    end else begin : g_body
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) r2_v_q[i] <= 1'b0;
        else if (en) r2_v_q[i] <= r2_v_q[i-1];
      end
      always_ff @(posedge clk_i) begin
        if (en) begin
          r2_q[i]   <= sqrt_step(r2_q[i-1]);
          r2_c_q[i] <= r2_c_q[i-1];
        end
      end
    end
  end

  // ---------------- d0: divider setup
  c2_t                r2_last;
  logic [SqRootW-1:0] r2_root;
  logic [NumW-1:0]    d_mx, d_my;
  logic               d0_v_q;
  c3_t                d0_c_q;
  div_t               d0_x_q, d0_y_q;

  assign r2_last = r2_c_q[SqSteps-1];
  assign r2_root = r2_q[SqSteps-1].root;
  assign d_mx = r2_last.numx[NumW-1] ? NumW'(-r2_last.numx) : NumW'(r2_last.numx);
  assign d_my = r2_last.numy[NumW-1] ? NumW'(-r2_last.numy) : NumW'(r2_last.numy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) d0_v_q <= 1'b0;
    else if (en) d0_v_q <= r2_v_q[SqSteps-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d0_c_q.eig_s  <= r2_last.eig_s;
      d0_c_q.eig_l  <= r2_last.eig_l;
      d0_c_q.q      <= r2_root;
      d0_c_q.negx   <= r2_last.numx[NumW-1];
      d0_c_q.negy   <= r2_last.numy[NumW-1];
      d0_c_q.clampx <= d_mx[SqRootW-1:0] >= r2_root;
      d0_c_q.clampy <= d_my[SqRootW-1:0] >= r2_root;
      d0_c_q.vdef   <= r2_last.vdef | (r2_root == '0);
      d0_c_q.code   <= r2_last.code;
      d0_x_q.rem    <= {1'b0, d_mx[SqRootW-1:0]};
      d0_x_q.quo    <= '0;
      d0_y_q.rem    <= {1'b0, d_my[SqRootW-1:0]};
      d0_y_q.quo    <= '0;
    end
  end

  // ---------------- divider, one quotient bit per stage for each component
  logic dv_v_q [DivSteps];
  div_t dv_x_q [DivSteps];
  div_t dv_y_q [DivSteps];
  c3_t  dv_c_q [DivSteps];

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    if (i == 0) begin : g_head
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) dv_v_q[i] <= 1'b0;
        else if (en) dv_v_q[i] <= d0_v_q;
      end
      always_ff @(posedge clk_i) begin
        if (en) begin
          dv_x_q[i] <= div_step(d0_x_q, d0_c_q.q);
          dv_y_q[i] <= div_step(d0_y_q, d0_c_q.q);
          dv_c_q[i] <= d0_c_q;
        end
      end
    end else begin : g_body
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) dv_v_q[i] <= 1'b0;
        else if (en) dv_v_q[i] <= dv_v_q[i-1];
      end
      always_ff @(posedge clk_i) begin
        if (en) begin
          dv_x_q[i] <= div_step(dv_x_q[i-1], dv_c_q[i-1].q);
          dv_y_q[i] <= div_step(dv_y_q[i-1], dv_c_q[i-1].q);
          dv_c_q[i] <= dv_c_q[i-1];
        end
      end
    end
  end

  // ---------------- output word
  c3_t         dv_last;
  logic [31:0] o_mx, o_my, o_x, o_y;
  logic        out_v_q;
  logic [127:0] out_data_q;
  logic [1:0]   out_user_q;

  assign dv_last = dv_c_q[DivSteps-1];
  assign o_mx = dv_last.clampx ? VEC_ONE : {2'b00, dv_x_q[DivSteps-1].quo};
  assign o_my = dv_last.clampy ? VEC_ONE : {2'b00, dv_y_q[DivSteps-1].quo};
  assign o_x  = dv_last.vdef ? VEC_ONE : (dv_last.negx ? -o_mx : o_mx);
  assign o_y  = dv_last.vdef ? 32'd0   : (dv_last.negy ? -o_my : o_my);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= dv_v_q[DivSteps-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= {o_y, o_x, dv_last.eig_l, dv_last.eig_s};
      out_user_q <= dv_last.code;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  // ---------------- checks
  a_code_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o == CASE_ZERO || m_axis_tuser_o == CASE_DOUBLE ||
                         m_axis_tuser_o == CASE_DISTINCT))
    else $error("illegal case code");

  a_zero_vals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == CASE_ZERO) |-> m_axis_tdata_o[63:0] == 64'd0)
    else $error("zero matrix with nonzero eigenvalues");

  a_default_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != CASE_DISTINCT) |->
      (m_axis_tdata_o[95:64] == VEC_ONE && m_axis_tdata_o[127:96] == 32'd0))
    else $error("default vector expected");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> $signed(m_axis_tdata_o[31:0]) <= $signed(m_axis_tdata_o[63:32]))
    else $error("eigenvalues out of order");

  a_double_eq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == CASE_DOUBLE) |->
      m_axis_tdata_o[31:0] == m_axis_tdata_o[63:32])
    else $error("double root with unequal eigenvalues");

endmodule
